// ===== src/text_line_compactor_core_macros.svh =====
// ----------------------------------------------------------------------------
// text_line_compactor_core_macros
// Assertion macros used by the compactor RTL (tlc_back); each expects clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_COMPACTOR_CORE_MACROS_SVH
`define TEXT_LINE_COMPACTOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TLC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TLC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TLC_ASSERT_IMP(lbl, ante, cons, msg)
`define TLC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types and constants of the text line compactor.
// ----------------------------------------------------------------------------
`default_nettype none
package tlc_pkg;

  localparam int unsigned MAX_LINE_DEF = 512;
  localparam int unsigned TAB_STOP_DEF = 8;
  localparam int unsigned SEQ_COL_W    = 12;
  localparam logic [SEQ_COL_W-1:0] SEQ_COL_RESET = 12'd72;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EOI   = 2'd1,
    KIND_DRAIN = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_SEEN = 2'd1,
    ESC_CSI  = 2'd2
  } esc_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EVAL = 2'd2
  } state_t;

  typedef enum logic [1:0] {
    REG_FORTRAN = 2'd0,
    REG_DROP    = 2'd1,
    REG_SEQCOL  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic                 fortran_trim;
    logic                 drop_blank_lines;
    logic [SEQ_COL_W-1:0] sequence_column;
  } cfg_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;

endpackage
`default_nettype wire

// ===== src/text_line_compactor_core.sv =====
// ----------------------------------------------------------------------------
// text_line_compactor_core
// Cleans a byte stream into a line store and emits each line tab-compacted.
// ----------------------------------------------------------------------------
// Data bytes, end-of-input items and drain items with no pending line are
// handled in the idle state. A drain with a pending line steps through scan
// and evaluate: a drain that emits a gap byte or a stored byte reads the
// blanks it skips plus the next non-blank, and a drain that closes the line
// reads the blanks skipped before the end of the line or the Fortran cut.
// Each read is one registered access of the line store (scan) followed by
// one evaluate step. A drain starts only once the result register is free.
// A two-entry queue between the input side and the engine lets the input
// keep flowing while the engine works, and the result register lets the
// engine continue with data items while a result waits downstream.
// Register map: 0x0 fortran_trim, 0x4 drop_blank_lines, 0x8 sequence_column.
// ----------------------------------------------------------------------------
`default_nettype none
module text_line_compactor_core #(
  parameter int unsigned MAX_LINE = tlc_pkg::MAX_LINE_DEF,
  parameter int unsigned TAB_STOP = tlc_pkg::TAB_STOP_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_byte, [8] out_valid, [9] overrun
  output logic             out_tlast,  // line_last
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  tlc_pkg::cfg_t  cfg_r;
  tlc_pkg::item_t q_item;
  logic q_valid, q_ready;
  logic [7:0] ob;
  logic of, ovr;
  tlc_pkg::reg_idx_t ridx;

  assign cfg_pready = 1'b1;
  assign ridx = tlc_pkg::reg_idx_t'(cfg_paddr[3:2]);

  // Write a register at the access phase; unknown addresses drop the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{fortran_trim: 1'b0, drop_blank_lines: 1'b0,
                 sequence_column: tlc_pkg::SEQ_COL_RESET};
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        tlc_pkg::REG_FORTRAN: cfg_r.fortran_trim     <= cfg_pwdata[0];
        tlc_pkg::REG_DROP:    cfg_r.drop_blank_lines <= cfg_pwdata[0];
        tlc_pkg::REG_SEQCOL:  cfg_r.sequence_column  <= cfg_pwdata[tlc_pkg::SEQ_COL_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero-extended.
  always_comb begin
    case (ridx)
      tlc_pkg::REG_FORTRAN: cfg_prdata = {31'd0, cfg_r.fortran_trim};
      tlc_pkg::REG_DROP:    cfg_prdata = {31'd0, cfg_r.drop_blank_lines};
      tlc_pkg::REG_SEQCOL:  cfg_prdata = {20'd0, cfg_r.sequence_column};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  tlc_front u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid), .in_ready (in_tready),
    .in_op    (in_tuser),  .in_data  (in_tdata),
    .q_valid, .q_ready, .q_item
  );

  tlc_back #(.MAX_LINE(MAX_LINE), .TAB_STOP(TAB_STOP)) u_back (
    .clk, .rst_n, .cfg (cfg_r),
    .q_valid, .q_ready, .q_item,
    .out_valid (out_tvalid), .out_ready (out_tready),
    .out_byte  (ob), .out_flag (of), .out_last (out_tlast), .out_ovr (ovr)
  );

  // Pack the result fields, lowest bit first.
  assign out_tdata = {6'd0, ovr, of, ob};
endmodule
`default_nettype wire

// ===== src/tlc_front.sv =====
// ----------------------------------------------------------------------------
// tlc_front
// Accepts input transfers, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module tlc_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     in_op,
  input  wire logic [7:0]     in_data,
  output logic                q_valid,
  input  wire logic           q_ready,
  output tlc_pkg::item_t      q_item
);
  tlc_pkg::item_t slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= '{kind: tlc_pkg::kind_t'(in_op), data: in_data};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== src/tlc_back.sv =====
// ----------------------------------------------------------------------------
// tlc_back
// Line store, cleaning logic and the drain sequencer with its result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_line_compactor_core_macros.svh"
module tlc_back #(
  parameter int unsigned MAX_LINE = tlc_pkg::MAX_LINE_DEF,
  parameter int unsigned TAB_STOP = tlc_pkg::TAB_STOP_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tlc_pkg::cfg_t  cfg,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire tlc_pkg::item_t q_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_flag,
  output logic                out_last,
  output logic                out_ovr
);
  localparam int AW   = $clog2(MAX_LINE);
  localparam int KW   = $clog2(MAX_LINE + 1);
  localparam int CW   = $clog2(MAX_LINE * TAB_STOP + 1);
  localparam int MW   = $clog2(TAB_STOP);
  localparam int CMPW = (CW > tlc_pkg::SEQ_COL_W) ? CW : tlc_pkg::SEQ_COL_W;
  localparam logic [MW-1:0] MOD_TOP = MW'(TAB_STOP - 1);

  logic [7:0] mem [MAX_LINE];
  logic [7:0] rdata_r;

  tlc_pkg::state_t state_r, state_nxt;
  tlc_pkg::esc_t   esc_r, esc_nxt;
  logic [KW-1:0] kept_r, kept_nxt, raw_r, raw_nxt, rd_r, rd_nxt;
  logic [CW-1:0] tcol_r, tcol_nxt, wcol_r, wcol_nxt;
  logic [MW-1:0] tmod_r, tmod_nxt, wmod_r, wmod_nxt;
  logic pend_r, pend_nxt, fact_r, fact_nxt, ovr_r, ovr_nxt;
  logic [7:0] first_r, first_nxt;
  logic ov_r, ov_nxt, of_r, of_nxt, ol_r, ol_nxt, oo_r, oo_nxt;
  logic [7:0] ob_r, ob_nxt;

  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          slot_free, at_end, fcut;
  logic [CW-1:0] nstop;
  logic [7:0]    b;

  assign slot_free = !ov_r || out_ready;
  assign at_end    = (rd_r >= kept_r);
  assign fcut      = fact_r && (CMPW'(tcol_r) >= CMPW'(cfg.sequence_column));
  assign nstop     = wcol_r + CW'(TAB_STOP) - CW'(wmod_r);
  assign b         = q_item.data;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[rd_r[AW-1:0]];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tlc_pkg::ST_IDLE: begin
        if (q_valid && q_item.kind == tlc_pkg::KIND_DRAIN && slot_free && pend_r)
          state_nxt = tlc_pkg::ST_SCAN;
      end
      tlc_pkg::ST_SCAN: state_nxt = (at_end || fcut) ? tlc_pkg::ST_IDLE : tlc_pkg::ST_EVAL;
      tlc_pkg::ST_EVAL: begin
        if (rdata_r == tlc_pkg::CH_TAB || rdata_r == tlc_pkg::CH_SPACE)
          state_nxt = tlc_pkg::ST_SCAN;
        else
          state_nxt = tlc_pkg::ST_IDLE;
      end
      default: state_nxt = tlc_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    esc_nxt = esc_r; kept_nxt = kept_r; raw_nxt = raw_r; rd_nxt = rd_r;
    tcol_nxt = tcol_r; wcol_nxt = wcol_r; tmod_nxt = tmod_r; wmod_nxt = wmod_r;
    pend_nxt = pend_r; fact_nxt = fact_r; ovr_nxt = ovr_r; first_nxt = first_r;
    ov_nxt = ov_r && !out_ready; of_nxt = of_r; ol_nxt = ol_r; ob_nxt = ob_r;
    oo_nxt = oo_r;
    we = 1'b0; waddr = kept_r[AW-1:0]; wdata = b; q_ready = 1'b0;
    case (state_r)
      tlc_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_item.kind)
            tlc_pkg::KIND_DATA: begin
              q_ready = 1'b1;
              if (pend_r) begin
                ovr_nxt = 1'b1;
              end else begin
                raw_nxt = raw_r + KW'(1);
                if (b != tlc_pkg::CH_LF) begin
                  if (esc_r == tlc_pkg::ESC_SEEN && b == tlc_pkg::CH_LBRK) begin
                    esc_nxt = tlc_pkg::ESC_CSI;
                  end else if (esc_r == tlc_pkg::ESC_CSI) begin
                    if (b < 8'h30 || b > 8'h39) esc_nxt = tlc_pkg::ESC_NONE;
                  end else begin
                    esc_nxt = tlc_pkg::ESC_NONE;
                    if (b == tlc_pkg::CH_BS || b == tlc_pkg::CH_DEL) begin
                      if (kept_r != '0) kept_nxt = kept_r - KW'(1);
                    end else if (b == tlc_pkg::CH_ESC) begin
                      esc_nxt = tlc_pkg::ESC_SEEN;
                    end else if (b == tlc_pkg::CH_TAB || (b >= 8'h20 && b <= 8'h7E)) begin
                      if (kept_r < KW'(MAX_LINE)) begin
                        we = 1'b1;
                        kept_nxt = kept_r + KW'(1);
                        if (kept_r == '0) first_nxt = b;
                      end
                    end
                  end
                end
                if (b == tlc_pkg::CH_LF || raw_nxt >= KW'(MAX_LINE - 1)) begin
                  pend_nxt = 1'b1; rd_nxt = '0; tcol_nxt = '0; wcol_nxt = '0;
                  tmod_nxt = '0; wmod_nxt = '0; raw_nxt = '0;
                  esc_nxt = tlc_pkg::ESC_NONE;
                  fact_nxt = cfg.fortran_trim && (kept_nxt == '0 ||
                    first_nxt == tlc_pkg::CH_TAB || first_nxt == tlc_pkg::CH_SPACE);
                end
              end
            end
            tlc_pkg::KIND_EOI: begin
              q_ready = 1'b1;
              if (!pend_r && raw_r != '0) begin
                pend_nxt = 1'b1; rd_nxt = '0; tcol_nxt = '0; wcol_nxt = '0;
                tmod_nxt = '0; wmod_nxt = '0; raw_nxt = '0;
                esc_nxt = tlc_pkg::ESC_NONE;
                fact_nxt = cfg.fortran_trim && (kept_r == '0 ||
                  first_r == tlc_pkg::CH_TAB || first_r == tlc_pkg::CH_SPACE);
              end
            end
            tlc_pkg::KIND_DRAIN: begin
              if (slot_free) begin
                q_ready = 1'b1;
                if (!pend_r) begin
                  ov_nxt = 1'b1; ob_nxt = 8'h00; of_nxt = 1'b0; ol_nxt = 1'b0;
                  oo_nxt = ovr_r;
                end
              end
            end
            default: q_ready = 1'b1;
          endcase
        end
      end
      tlc_pkg::ST_SCAN: begin
        if (at_end || fcut) begin
          pend_nxt = 1'b0; kept_nxt = '0; rd_nxt = '0; tcol_nxt = '0; wcol_nxt = '0;
          tmod_nxt = '0; wmod_nxt = '0;
          ov_nxt = 1'b1; oo_nxt = ovr_r;
          if (wcol_r == '0 && cfg.drop_blank_lines) begin
            ob_nxt = 8'h00; of_nxt = 1'b0; ol_nxt = 1'b0;
          end else begin
            ob_nxt = tlc_pkg::CH_LF; of_nxt = 1'b1; ol_nxt = 1'b1;
          end
        end
      end
      tlc_pkg::ST_EVAL: begin
        if (rdata_r == tlc_pkg::CH_TAB) begin
          tcol_nxt = tcol_r + CW'(TAB_STOP) - CW'(tmod_r);
          tmod_nxt = '0;
          rd_nxt   = rd_r + KW'(1);
        end else if (rdata_r == tlc_pkg::CH_SPACE) begin
          tcol_nxt = tcol_r + CW'(1);
          tmod_nxt = (tmod_r == MOD_TOP) ? '0 : tmod_r + MW'(1);
          rd_nxt   = rd_r + KW'(1);
        end else if (tcol_r > wcol_r) begin
          ov_nxt = 1'b1; of_nxt = 1'b1; ol_nxt = 1'b0; oo_nxt = ovr_r;
          if (wmod_r == MOD_TOP || nstop > tcol_r) begin
            ob_nxt   = tlc_pkg::CH_SPACE;
            wcol_nxt = wcol_r + CW'(1);
            wmod_nxt = (wmod_r == MOD_TOP) ? '0 : wmod_r + MW'(1);
          end else begin
            ob_nxt   = tlc_pkg::CH_TAB;
            wcol_nxt = nstop;
            wmod_nxt = '0;
          end
        end else begin
          ov_nxt = 1'b1; of_nxt = 1'b1; ol_nxt = 1'b0; ob_nxt = rdata_r;
          oo_nxt   = ovr_r;
          rd_nxt   = rd_r + KW'(1);
          tcol_nxt = tcol_r + CW'(1);
          wcol_nxt = tcol_r + CW'(1);
          tmod_nxt = (tmod_r == MOD_TOP) ? '0 : tmod_r + MW'(1);
          wmod_nxt = (tmod_r == MOD_TOP) ? '0 : tmod_r + MW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlc_pkg::ST_IDLE; esc_r <= tlc_pkg::ESC_NONE;
      kept_r <= '0; raw_r <= '0; rd_r <= '0; tcol_r <= '0; wcol_r <= '0;
      tmod_r <= '0; wmod_r <= '0; pend_r <= 1'b0; fact_r <= 1'b0; ovr_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; esc_r <= esc_nxt;
      kept_r <= kept_nxt; raw_r <= raw_nxt; rd_r <= rd_nxt;
      tcol_r <= tcol_nxt; wcol_r <= wcol_nxt; tmod_r <= tmod_nxt; wmod_r <= wmod_nxt;
      pend_r <= pend_nxt; fact_r <= fact_nxt; ovr_r <= ovr_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt; ob_r <= ob_nxt; of_r <= of_nxt; ol_r <= ol_nxt;
    oo_r <= oo_nxt;
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_flag  = of_r;
  assign out_last  = ol_r;
  assign out_ovr   = oo_r;

  `TLC_ASSERT_IMP(a_kept_bound, 1'b1, kept_r <= KW'(MAX_LINE), "kept count past store depth")
  `TLC_ASSERT_IMP(a_cols, pend_r, wcol_r <= tcol_r, "written column ahead of target")
  `TLC_ASSERT_IMP(a_scan_pend, state_r != tlc_pkg::ST_IDLE, pend_r && rd_r < KW'(MAX_LINE) + KW'(1),
    "drain active without a pending line")
  `TLC_ASSERT_NXT(a_eval_follows, state_r == tlc_pkg::ST_EVAL, state_r == tlc_pkg::ST_IDLE ||
    state_r == tlc_pkg::ST_SCAN, "bad step after evaluate")
endmodule
`default_nettype wire

// ===== tb/sv/tlc_checker.sv =====
// ----------------------------------------------------------------------------
// tlc_checker
// Watches the input, output and register ports of the line compactor, keeps
// its own model of the line store and tab compaction, and compares every
// output transfer with the oldest predicted byte.
// ----------------------------------------------------------------------------
module tlc_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic [1:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,
  input  wire logic        out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output int               fail_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       last;
    logic       ovr;
  } emit_t;

  emit_t      emit_q[$];
  logic [7:0] store[tlc_pkg::MAX_LINE_DEF];
  int unsigned kept, raw, rd_idx, tgt_col, wr_col;
  tlc_pkg::esc_t esc;
  logic       pending, fort_on, ovr_flag;
  logic       c_fort, c_drop;
  logic [11:0] c_seq;

  assign pending_count = emit_q.size();

  function automatic void close_line();
    pending = 1'b1;
    rd_idx  = 0;
    tgt_col = 0;
    wr_col  = 0;
    fort_on = c_fort && (kept == 0 || store[0] == tlc_pkg::CH_TAB ||
                         store[0] == tlc_pkg::CH_SPACE);
    raw     = 0;
    esc     = tlc_pkg::ESC_NONE;
  endfunction

  function automatic void clean(logic [7:0] b);
    if (esc == tlc_pkg::ESC_SEEN && b == tlc_pkg::CH_LBRK) begin
      esc = tlc_pkg::ESC_CSI;
      return;
    end
    if (esc == tlc_pkg::ESC_CSI) begin
      if (b < "0" || b > "9") esc = tlc_pkg::ESC_NONE;
      return;
    end
    esc = tlc_pkg::ESC_NONE;
    if (b == tlc_pkg::CH_BS || b == tlc_pkg::CH_DEL) begin
      if (kept > 0) kept--;
    end else if (b == tlc_pkg::CH_ESC) begin
      esc = tlc_pkg::ESC_SEEN;
    end else if (b == tlc_pkg::CH_TAB || (b >= 8'h20 && b <= 8'h7E)) begin
      if (kept < tlc_pkg::MAX_LINE_DEF) begin
        store[kept] = b;
        kept++;
      end
    end
  endfunction

  // Produce the next compacted byte of the pending line.
  function automatic emit_t next_emit();
    emit_t      e;
    logic [7:0] c;
    int unsigned stop;
    logic       blank;
    e = '0;
    while (rd_idx < kept) begin
      c = store[rd_idx];
      if (c == tlc_pkg::CH_TAB)
        tgt_col = tlc_pkg::TAB_STOP_DEF * (tgt_col / tlc_pkg::TAB_STOP_DEF + 1);
      else if (c == tlc_pkg::CH_SPACE) tgt_col++;
      else break;
      rd_idx++;
    end
    if (rd_idx >= kept || (fort_on && tgt_col >= c_seq)) begin
      blank   = (wr_col == 0);
      pending = 1'b0;
      kept    = 0;
      rd_idx  = 0;
      tgt_col = 0;
      wr_col  = 0;
      if (blank && c_drop) return e;
      e.ch = tlc_pkg::CH_LF;
      e.valid = 1'b1;
      e.last = 1'b1;
      return e;
    end
    e.valid = 1'b1;
    if (tgt_col > wr_col) begin
      stop = tlc_pkg::TAB_STOP_DEF * (wr_col / tlc_pkg::TAB_STOP_DEF + 1);
      if (wr_col % tlc_pkg::TAB_STOP_DEF == tlc_pkg::TAB_STOP_DEF - 1 || stop > tgt_col) begin
        e.ch = tlc_pkg::CH_SPACE;
        wr_col++;
      end else begin
        e.ch = tlc_pkg::CH_TAB;
        wr_col = stop;
      end
      return e;
    end
    e.ch = store[rd_idx];
    rd_idx++;
    tgt_col++;
    wr_col = tgt_col;
    return e;
  endfunction

  always @(posedge clk) begin
    emit_t e;
    emit_t got;
    if (!rst_n) begin
      emit_q.delete();
      kept = 0; raw = 0; rd_idx = 0; tgt_col = 0; wr_col = 0;
      esc = tlc_pkg::ESC_NONE; pending = 0; fort_on = 0; ovr_flag = 0;
      c_fort = 0; c_drop = 0; c_seq = tlc_pkg::SEQ_COL_RESET;
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (tlc_pkg::reg_idx_t'(cfg_paddr[3:2]))
          tlc_pkg::REG_FORTRAN: c_fort = cfg_pwdata[0];
          tlc_pkg::REG_DROP:    c_drop = cfg_pwdata[0];
          tlc_pkg::REG_SEQCOL:  c_seq  = cfg_pwdata[11:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        case (tlc_pkg::kind_t'(in_tuser))
          tlc_pkg::KIND_DATA: begin
            if (pending) begin
              ovr_flag = 1'b1;
            end else begin
              raw++;
              if (in_tdata != tlc_pkg::CH_LF) clean(in_tdata);
              if (in_tdata == tlc_pkg::CH_LF || raw >= tlc_pkg::MAX_LINE_DEF - 1) close_line();
            end
          end
          tlc_pkg::KIND_EOI: if (!pending && raw > 0) close_line();
          tlc_pkg::KIND_DRAIN: begin
            e = pending ? next_emit() : emit_t'('0);
            e.ovr = ovr_flag;
            emit_q.push_back(e);
          end
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[7:0], out_tdata[8], out_tlast, out_tdata[9]};
        if (emit_q.size() == 0) begin
          $error("unexpected output transfer %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = emit_q.pop_front();
          if (got != e) fail_count <= fail_count + 1;
          if (got.ch != e.ch) $error("out_byte exp %h got %h", e.ch, got.ch);
          if (got.valid != e.valid) $error("out_valid exp %b got %b", e.valid, got.valid);
          if (got.last != e.last) $error("line_last exp %b got %b", e.last, got.last);
          if (got.ovr != e.ovr) $error("overrun exp %b got %b", e.ovr, got.ovr);
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives text lines, escapes, control bytes and drains into the compactor
// under several register settings and idle patterns; the checker judges.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;

  logic        clk = 0, rst_n = 0;
  logic        in_tvalid = 0, out_tready = 0;
  logic [7:0]  in_tdata = 0;
  logic [1:0]  in_tuser = 0;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [3:0]  cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  wire         in_tready, out_tvalid, out_tlast, cfg_pready;
  wire [15:0]  out_tdata;
  wire [31:0]  cfg_prdata;
  int          fail_count, pending_count;
  int          send_idle_pct, recv_stall_pct, quiet;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  text_line_compactor_core uut (.*);

  tlc_checker chk (.*);

  // Stall the output side at the current rate.
  always @(posedge clk)
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

  // Count cycles without any transfer; give up past the limit.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Maybe idle first, then present one item and hold it until accepted.
  // Valid stays high afterwards; drain_settle drops it.
  task automatic send(tlc_pkg::kind_t k, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= k;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_settle();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic reg_write(tlc_pkg::reg_idx_t r, logic [31:0] v);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= {r, 2'b00}; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  // Send n drain items, whether or not a line is still pending.
  task automatic drain_n(int n);
    repeat (n) send(tlc_pkg::KIND_DRAIN, 8'h00);
  endtask

  function automatic logic [7:0] rand_char();
    int r;
    r = $urandom_range(99);
    if (r < 35) return tlc_pkg::CH_SPACE;
    if (r < 45) return tlc_pkg::CH_TAB;
    if (r < 85) return 8'($urandom_range(8'h7E, 8'h21));
    if (r < 90) return tlc_pkg::CH_BS;
    if (r < 93) return tlc_pkg::CH_ESC;
    return 8'($urandom_range(255));
  endfunction

  // One random line: content, terminator, then drains enough to empty it.
  task automatic rand_line(int maxlen);
    int len;
    len = $urandom_range(maxlen);
    for (int i = 0; i < len; i++) send(tlc_pkg::KIND_DATA, rand_char());
    if ($urandom_range(9) == 0) send(tlc_pkg::KIND_EOI, 8'h00);
    else send(tlc_pkg::KIND_DATA, tlc_pkg::CH_LF);
    drain_n(len + 2 + $urandom_range(1));
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty drain, escapes, gap of blanks, overrun, long line, nop.
    send(tlc_pkg::KIND_DRAIN, 8'h00);
    send(tlc_pkg::KIND_EOI, 8'h00);
    send(tlc_pkg::KIND_DATA, 8'h41); send(tlc_pkg::KIND_DATA, tlc_pkg::CH_ESC);
    send(tlc_pkg::KIND_DATA, tlc_pkg::CH_LBRK);
    send(tlc_pkg::KIND_DATA, "3"); send(tlc_pkg::KIND_DATA, "m");
    send(tlc_pkg::KIND_DATA, tlc_pkg::CH_ESC);
    send(tlc_pkg::KIND_DATA, "x"); send(tlc_pkg::KIND_DATA, tlc_pkg::CH_DEL);
    send(tlc_pkg::KIND_DATA, 8'hFF);
    send(tlc_pkg::KIND_DATA, 8'h00); send(tlc_pkg::KIND_DATA, 8'h7E);
    for (int i = 0; i < 7; i++) send(tlc_pkg::KIND_DATA, tlc_pkg::CH_SPACE);
    send(tlc_pkg::KIND_DATA, tlc_pkg::CH_TAB); send(tlc_pkg::KIND_DATA, 8'h20);
    send(tlc_pkg::KIND_DATA, "z");
    send(tlc_pkg::KIND_DATA, tlc_pkg::CH_SPACE); send(tlc_pkg::KIND_DATA, tlc_pkg::CH_LF);
    send(tlc_pkg::KIND_DATA, 8'h80);
    send(tlc_pkg::KIND_NOP, 8'hAA);
    send(tlc_pkg::KIND_EOI, 8'h00);
    drain_n(8);
    for (int i = 0; i < 520; i++)
      send(tlc_pkg::KIND_DATA, (i % 9 == 0) ? tlc_pkg::CH_TAB : 8'h61);
    drain_n(60);
    drain_settle();

    // Random phases over register settings and idle patterns.
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(tlc_pkg::REG_FORTRAN, {31'd0, ph[0]});
      reg_write(tlc_pkg::REG_DROP, {31'd0, ph[1]});
      case (ph)
        0, 1:    reg_write(tlc_pkg::REG_SEQCOL, 12);
        2:       reg_write(tlc_pkg::REG_SEQCOL, 0);
        3:       reg_write(tlc_pkg::REG_SEQCOL, 12'hFFF);
        4:       reg_write(tlc_pkg::REG_SEQCOL, 1);
        default: reg_write(tlc_pkg::REG_SEQCOL, $urandom_range(30, 1));
      endcase
      send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? 77 : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? 77 : 0;
      if (ph % 4 == 3) begin send_idle_pct = 25; recv_stall_pct = 25; end
      for (int n = 0; n < 3; n++) begin
        if ($urandom_range(5) == 0) send(tlc_pkg::KIND_DATA, rand_char());
        rand_line(20);
      end
      drain_settle();
    end
    send(tlc_pkg::KIND_DATA, 8'h55);
    send(tlc_pkg::KIND_EOI, 8'h00);
    send(tlc_pkg::KIND_DATA, 8'h01);
    drain_n(3);
    drain_settle();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
